FILE: rtl/core/mfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
// Used by mfq_ctrl, mfq_dp and the top level; depends on nothing else.
package mfq_pkg;

	// Field widths fixed by the interface
	localparam int ID_W        = 8;
	localparam int SERV_W      = 16;
	localparam int TIME_W      = 32;
	localparam int QNT_W       = 8;
	localparam int RUN_LEVEL_W = 2;
	localparam int ENTRY_W     = ID_W + SERV_W + 1;

	// Quantum registers, levels past the last one reuse the last quantum
	localparam int NUM_QUANTA = 4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCH_OVH = 3'd4;

	localparam logic [QNT_W-1:0] QUANTUM_RESET = 8'd1;

	// Default sizes
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_NUM_LEVELS  = 4;

	// Commands from controller to datapath
	typedef struct packed {
		logic arrive;  // request accepted: enqueue the arrival
		logic slice;   // retire or demote the current job
		logic pop;     // read the head of the highest nonempty level
		logic run;     // run one time unit and load the result
	} mfq_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic pop_ready;  // CPU free and some job waiting
	} mfq_stat_t;

endpackage

FILE: rtl/core/mfq_ctrl.sv
// Sequencer of the scheduler: steps one request through slice, pop and run.
// Depends on mfq_pkg for the command and status structs.
module mfq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mfq_pkg::mfq_stat_t stat,
	output mfq_pkg::mfq_cmd_t  cmd
);
	import mfq_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SLICE = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_RUN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	// Issue commands
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.arrive = in_valid && (state_q == ST_IDLE);
		cmd.slice  = (state_q == ST_SLICE);
		cmd.pop    = (state_q == ST_READ) && stat.pop_ready;
		cmd.run    = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SLICE;
			ST_SLICE: state_d = ST_READ;
			ST_READ:  state_d = ST_RUN;
			ST_RUN:   if (cmd.run) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.run) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/mfq_dp.sv
// Datapath of the scheduler: level queues in one memory, current job, clock.
// Depends on mfq_pkg; driven by commands from mfq_ctrl.
module mfq_dp #(
	parameter int QUEUE_DEPTH = mfq_pkg::DEF_QUEUE_DEPTH,
	parameter int NUM_LEVELS  = mfq_pkg::DEF_NUM_LEVELS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mfq_pkg::mfq_cmd_t                 cmd,
	output mfq_pkg::mfq_stat_t                stat,
	input  logic                              cfg_we,
	input  logic [mfq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mfq_pkg::QNT_W-1:0]         cfg_wdata,
	input  logic                              arrive_valid,
	input  logic [mfq_pkg::ID_W-1:0]          arrive_id,
	input  logic [mfq_pkg::SERV_W-1:0]        arrive_service,
	output logic [mfq_pkg::ID_W-1:0]          run_id,
	output logic [mfq_pkg::RUN_LEVEL_W-1:0]   run_level,
	output logic [mfq_pkg::TIME_W-1:0]        time_now,
	output logic                              first_run,
	output logic                              done_valid,
	output logic [mfq_pkg::ID_W-1:0]          done_id,
	output logic [mfq_pkg::TIME_W-1:0]        done_time,
	output logic                              all_idle,
	output logic                              arrival_dropped
);
	import mfq_pkg::*;

	localparam int LVL_W     = $clog2(NUM_LEVELS);
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(NUM_LEVELS - 1);

	// Quantum register index of a level
	function automatic logic [1:0] qidx(input logic [LVL_W-1:0] lvl);
		logic [1:0] r;
		if (int'(lvl) < NUM_QUANTA) begin
			r = 2'(lvl);
		end else begin
			r = 2'(NUM_QUANTA - 1);
		end
		return r;
	endfunction

	// Memory address of a queue slot
	function automatic logic [AW-1:0] slot(input logic [LVL_W-1:0] lvl,
			input logic [PTR_W-1:0] ptr);
		return AW'(AW'(lvl) * AW'(QUEUE_DEPTH) + AW'(ptr));
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_LAST) ? '0 : PTR_W'(ptr + 1'b1);
	endfunction

	// Configuration
	logic [QNT_W-1:0]  quant_q [NUM_QUANTA];
	logic [QNT_W-1:0]  ovh_q;

	// Queue control
	logic [PTR_W-1:0]  head_q [NUM_LEVELS];
	logic [PTR_W-1:0]  tail_q [NUM_LEVELS];
	logic [CNT_W-1:0]  cnt_q  [NUM_LEVELS];

	// Current job and clock
	logic [ID_W-1:0]   cur_id_q;
	logic [SERV_W-1:0] cur_rem_q;
	logic              cur_started_q;
	logic [LVL_W-1:0]  cur_level_q;
	logic [QNT_W-1:0]  slice_q;
	logic [TIME_W-1:0] clock_q;

	// Per-request bookkeeping
	logic              busy_q;
	logic              loaded_q;
	logic [LVL_W-1:0]  pop_level_q;
	logic              done_valid_q;
	logic [ID_W-1:0]   done_id_q;
	logic [TIME_W-1:0] done_time_q;
	logic              dropped_q;

	// Queue memory
	logic [ENTRY_W-1:0] mem [MEM_DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	logic               any_wait;
	logic [LVL_W-1:0]   high_lvl;
	logic               busy;
	logic [LVL_W-1:0]   target_lvl;
	logic               arr_take;
	logic               arr_push;
	logic               slice_out;
	logic               dem_push;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [AW-1:0]      rd_addr;

	logic [ID_W-1:0]    eff_id;
	logic [SERV_W-1:0]  eff_rem;
	logic               eff_started;
	logic [LVL_W-1:0]   eff_level;
	logic [QNT_W-1:0]   eff_slice;

	// Find the highest nonempty level
	always_comb begin
		any_wait = 1'b0;
		high_lvl = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				any_wait = 1'b1;
				high_lvl = LVL_W'(i);
			end
		end
	end

	// Decide pushes for arrival and demotion
	always_comb begin
		busy       = (cur_id_q != '0);
		target_lvl = (cur_level_q == LVL_LAST) ? cur_level_q : LVL_W'(cur_level_q + 1'b1);
		arr_take   = cmd.arrive && arrive_valid && (arrive_id != '0);
		arr_push   = arr_take && (cnt_q[0] != CNT_FULL);
		slice_out  = cmd.slice && busy && (cur_rem_q != '0) && (slice_q == '0);
		dem_push   = slice_out && any_wait && !(high_lvl > target_lvl)
			&& (cnt_q[target_lvl] != CNT_FULL);
		wr_en      = arr_push || dem_push;
		wr_addr    = arr_push ? slot('0, tail_q[0]) : slot(target_lvl, tail_q[target_lvl]);
		wr_data    = arr_push ? {1'b0, arrive_service, arrive_id}
			: {cur_started_q, cur_rem_q, cur_id_q};
		rd_addr    = slot(high_lvl, head_q[high_lvl]);
		stat.pop_ready = !busy && any_wait;
	end

	// Select the job that runs: a fresh pop or the one holding the CPU
	always_comb begin
		if (loaded_q) begin
			eff_id      = rd_q[ID_W-1:0];
			eff_rem     = rd_q[ID_W+SERV_W-1:ID_W];
			eff_started = rd_q[ENTRY_W-1];
			eff_level   = pop_level_q;
			eff_slice   = quant_q[qidx(pop_level_q)];
		end else begin
			eff_id      = cur_id_q;
			eff_rem     = cur_rem_q;
			eff_started = cur_started_q;
			eff_level   = cur_level_q;
			eff_slice   = slice_q;
		end
	end

	// Write and read the queue memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.pop) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Advance queue pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				if ((arr_push && l == 0) || (dem_push && int'(target_lvl) == l)) begin
					tail_q[l] <= ptr_inc(tail_q[l]);
					cnt_q[l]  <= CNT_W'(cnt_q[l] + 1'b1);
				end else if (cmd.pop && int'(high_lvl) == l) begin
					head_q[l] <= ptr_inc(head_q[l]);
					cnt_q[l]  <= CNT_W'(cnt_q[l] - 1'b1);
				end
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUANTA; i++) begin
				quant_q[i] <= QUANTUM_RESET;
			end
			ovh_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUANTUM0:   quant_q[0] <= cfg_wdata;
				REG_QUANTUM1:   quant_q[1] <= cfg_wdata;
				REG_QUANTUM2:   quant_q[2] <= cfg_wdata;
				REG_QUANTUM3:   quant_q[3] <= cfg_wdata;
				REG_SWITCH_OVH: ovh_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Current job, clock and request bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_id_q      <= '0;
			cur_rem_q     <= '0;
			cur_started_q <= 1'b0;
			cur_level_q   <= '0;
			slice_q       <= '0;
			clock_q       <= '0;
			busy_q        <= 1'b0;
			loaded_q      <= 1'b0;
			pop_level_q   <= '0;
			dropped_q     <= 1'b0;
			done_valid_q  <= 1'b0;
			done_id_q     <= '0;
			done_time_q   <= '0;
		end else begin
			if (cmd.arrive) begin
				dropped_q <= arr_take && !arr_push;
			end
			if (cmd.slice) begin
				busy_q   <= busy;
				loaded_q <= 1'b0;
				if (busy && cur_rem_q == '0) begin
					// retire the finished job
					done_valid_q <= 1'b1;
					done_id_q    <= cur_id_q;
					done_time_q  <= clock_q;
					cur_id_q     <= '0;
				end else begin
					done_valid_q <= 1'b0;
					done_id_q    <= '0;
					done_time_q  <= '0;
					if (slice_out) begin
						if (!any_wait) begin
							slice_q <= quant_q[qidx(cur_level_q)];
						end else if (high_lvl > target_lvl) begin
							// drop a level and keep the CPU
							cur_level_q <= target_lvl;
							slice_q     <= quant_q[qidx(target_lvl)];
						end else if (cnt_q[target_lvl] == CNT_FULL) begin
							slice_q <= quant_q[qidx(cur_level_q)];
						end else begin
							cur_id_q <= '0;
						end
					end
				end
			end
			if (cmd.pop) begin
				loaded_q    <= 1'b1;
				pop_level_q <= high_lvl;
				if (busy_q) begin
					clock_q <= clock_q + TIME_W'(ovh_q);
				end
			end
			if (cmd.run) begin
				cur_id_q    <= eff_id;
				cur_level_q <= eff_level;
				clock_q     <= clock_q + 1'b1;
				if (eff_id != '0) begin
					cur_started_q <= 1'b1;
					cur_rem_q     <= (eff_rem != '0) ? SERV_W'(eff_rem - 1'b1) : '0;
					slice_q       <= (eff_slice != '0) ? QNT_W'(eff_slice - 1'b1) : '0;
				end else begin
					cur_started_q <= eff_started;
					cur_rem_q     <= eff_rem;
					slice_q       <= eff_slice;
				end
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.run) begin
			run_id          <= eff_id;
			run_level       <= (eff_id != '0) ? RUN_LEVEL_W'(eff_level) : '0;
			time_now        <= clock_q;
			first_run       <= (eff_id != '0) && !eff_started;
			done_valid      <= done_valid_q;
			done_id         <= done_id_q;
			done_time       <= done_time_q;
			all_idle        <= (eff_id == '0);
			arrival_dropped <= dropped_q;
		end
	end

endmodule

FILE: rtl/core/multilevel_feedback_queue_scheduler.sv
// Four-level feedback queue scheduler, top level.
// Instantiates mfq_ctrl and mfq_dp; depends on mfq_pkg.
//
// Usage:
//  Each input request is one scheduler tick: an optional arrival (arrive_valid,
//  arrive_id, arrive_service) that joins level 0. Each tick gives exactly one
//  result: the job run, its level, the clock at which it ran, a first-run flag,
//  a completion report for the job that finished before this tick, an idle flag
//  and a flag for an arrival dropped on a full level 0.
//  Both channels use valid/ready. A request is taken in the accept cycle, then
//  passes a slice step, a queue read step and a run step, after which the result
//  is valid. One request is in work at a time: no new request is taken until the
//  last one has passed its run step. The queue memory is written on the arrival
//  and demotion steps and read on the pop step.
//  A finished result waits in the output register; the next request is taken
//  meanwhile and holds in its run step while the receiver stalls.
//  Reset clears the queues (by count), the current job, the clock, and sets all
//  quanta to one and the switch overhead to zero. Queue entries need no clear.
//  Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once. The
//  user must make them only while the block is idle; the block does not enforce it.
module multilevel_feedback_queue_scheduler #(
	parameter int QUEUE_DEPTH = mfq_pkg::DEF_QUEUE_DEPTH,
	parameter int NUM_LEVELS  = mfq_pkg::DEF_NUM_LEVELS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              arrive_valid,
	input  logic [mfq_pkg::ID_W-1:0]          arrive_id,
	input  logic [mfq_pkg::SERV_W-1:0]        arrive_service,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mfq_pkg::ID_W-1:0]          run_id,
	output logic [mfq_pkg::RUN_LEVEL_W-1:0]   run_level,
	output logic [mfq_pkg::TIME_W-1:0]        time_now,
	output logic                              first_run,
	output logic                              done_valid,
	output logic [mfq_pkg::ID_W-1:0]          done_id,
	output logic [mfq_pkg::TIME_W-1:0]        done_time,
	output logic                              all_idle,
	output logic                              arrival_dropped,
	input  logic                              cfg_we,
	input  logic [mfq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mfq_pkg::QNT_W-1:0]         cfg_wdata
);
	import mfq_pkg::*;

	mfq_cmd_t  cmd;
	mfq_stat_t stat;

	mfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mfq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_LEVELS  (NUM_LEVELS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.arrive_valid    (arrive_valid),
		.arrive_id       (arrive_id),
		.arrive_service  (arrive_service),
		.run_id          (run_id),
		.run_level       (run_level),
		.time_now        (time_now),
		.first_run       (first_run),
		.done_valid      (done_valid),
		.done_id         (done_id),
		.done_time       (done_time),
		.all_idle        (all_idle),
		.arrival_dropped (arrival_dropped)
	);

	// Only one request is in work at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in work");

	// A first run always names a real job
	a_first_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_run |-> run_id != '0 && !all_idle)
		else $error("first run flagged without a job");

	// A completion always names a real job
	a_done_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_valid |-> done_id != '0)
		else $error("completion reported without a job id");

	// A run step loads a result only into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run |-> !out_valid || out_ready)
		else $error("result overwritten while stalled");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the multilevel feedback queue scheduler: a tick-level
// predictor runs beside the block and every result is compared field by field.
// Depends on mfq_pkg and multilevel_feedback_queue_scheduler only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mfq_pkg::*;

	localparam int QDEPTH       = DEF_QUEUE_DEPTH;
	localparam int LEVELS       = DEF_NUM_LEVELS;
	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE       = 8;
	localparam int PRINT_CAP    = 100;
	// Indexes above the overhead register decode to nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_SWITCH_OVH + 1'b1;
	localparam int SPARE_REGS = (1 << CFG_IDX_W) - 1 - int'(REG_SWITCH_OVH);

	// One waiting job as the scheduler keeps it
	typedef struct packed {
		logic              started;
		logic [SERV_W-1:0] remaining;
		logic [ID_W-1:0]   id;
	} job_entry_t;

	// Everything the block reports for one tick
	typedef struct packed {
		logic [ID_W-1:0]        run_id;
		logic [RUN_LEVEL_W-1:0] run_level;
		logic [TIME_W-1:0]      time_now;
		logic                   first_run;
		logic                   done_valid;
		logic [ID_W-1:0]        done_id;
		logic [TIME_W-1:0]      done_time;
		logic                   all_idle;
		logic                   arrival_dropped;
	} tick_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   arrive_valid = 1'b0;
	logic [ID_W-1:0]        arrive_id = '0;
	logic [SERV_W-1:0]      arrive_service = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [ID_W-1:0]        run_id;
	logic [RUN_LEVEL_W-1:0] run_level;
	logic [TIME_W-1:0]      time_now;
	logic                   first_run;
	logic                   done_valid;
	logic [ID_W-1:0]        done_id;
	logic [TIME_W-1:0]      done_time;
	logic                   all_idle;
	logic                   arrival_dropped;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [QNT_W-1:0]       cfg_wdata = '0;

	// Predictor state: per-level ready queues, the running job and the clock
	job_entry_t        ready_jobs [LEVELS][$];
	logic [QNT_W-1:0]  quantum_cfg [NUM_QUANTA];
	logic [QNT_W-1:0]  overhead_cfg;
	logic [ID_W-1:0]   cur_id;
	logic [SERV_W-1:0] cur_left;
	logic              cur_started;
	int                cur_lvl;
	logic [QNT_W-1:0]  slice_cnt;
	logic [TIME_W-1:0] sched_clock;

	tick_result_t pending_ticks [$];
	bit           idle_on = 1'b1;
	int           stall_left = 0;
	int           err_count = 0;
	int           result_count = 0;
	int           cycle_count = 0;

	multilevel_feedback_queue_scheduler i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.arrive_valid    (arrive_valid),
		.arrive_id       (arrive_id),
		.arrive_service  (arrive_service),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.run_id          (run_id),
		.run_level       (run_level),
		.time_now        (time_now),
		.first_run       (first_run),
		.done_valid      (done_valid),
		.done_id         (done_id),
		.done_time       (done_time),
		.all_idle        (all_idle),
		.arrival_dropped (arrival_dropped),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void reset_schedule();
		for (int l = 0; l < LEVELS; l++) begin
			ready_jobs[l].delete();
		end
		for (int q = 0; q < NUM_QUANTA; q++) begin
			quantum_cfg[q] = QUANTUM_RESET;
		end
		overhead_cfg = '0;
		cur_id = '0;
		cur_left = '0;
		cur_started = 1'b0;
		cur_lvl = 0;
		slice_cnt = '0;
		sched_clock = '0;
	endfunction

	function automatic logic [QNT_W-1:0] quantum_for(input int lvl);
		return quantum_cfg[(lvl < NUM_QUANTA) ? lvl : NUM_QUANTA - 1];
	endfunction

	function automatic int top_level();
		for (int l = 0; l < LEVELS; l++) begin
			if (ready_jobs[l].size() != 0) return l;
		end
		return LEVELS;
	endfunction

	// Advance the schedule by one tick and return what the block should report
	function automatic tick_result_t schedule_tick(input logic av, input logic [ID_W-1:0] id,
		input logic [SERV_W-1:0] serv);
		tick_result_t r;
		job_entry_t   e;
		logic         had_job;
		logic         switched;
		int           top;
		int           target;
		r = '0;
		switched = 1'b0;

		// Enqueue the arrival at level 0, drop it when level 0 is full
		if (av && id != '0) begin
			if (ready_jobs[0].size() < QDEPTH) begin
				e.started = 1'b0;
				e.remaining = serv;
				e.id = id;
				ready_jobs[0].insert(ready_jobs[0].size(), e);
			end else begin
				r.arrival_dropped = 1'b1;
			end
		end

		// Retire a finished job or handle a used-up slice
		had_job = (cur_id != '0);
		if (had_job && cur_left == '0) begin
			r.done_valid = 1'b1;
			r.done_id = cur_id;
			r.done_time = sched_clock;
			cur_id = '0;
		end else if (had_job && slice_cnt == '0) begin
			target = (cur_lvl >= LEVELS - 1) ? cur_lvl : cur_lvl + 1;
			top = top_level();
			if (top >= LEVELS) begin
				slice_cnt = quantum_for(cur_lvl);
			end else if (top > target) begin
				cur_lvl = target;
				slice_cnt = quantum_for(target);
			end else if (ready_jobs[target].size() >= QDEPTH) begin
				slice_cnt = quantum_for(cur_lvl);
			end else begin
				e.started = cur_started;
				e.remaining = cur_left;
				e.id = cur_id;
				ready_jobs[target].insert(ready_jobs[target].size(), e);
				cur_id = '0;
			end
		end

		// Dispatch from the highest nonempty level when the CPU is free
		if (cur_id == '0) begin
			top = top_level();
			if (top < LEVELS) begin
				e = ready_jobs[top].pop_front();
				cur_id = e.id;
				cur_left = e.remaining;
				cur_started = e.started;
				cur_lvl = top;
				slice_cnt = quantum_for(top);
				switched = had_job;
			end
		end

		if (switched) sched_clock += TIME_W'(overhead_cfg);
		r.time_now = sched_clock;

		// Run the current job for one time unit
		if (cur_id != '0) begin
			r.run_id = cur_id;
			r.run_level = RUN_LEVEL_W'(cur_lvl);
			r.first_run = !cur_started;
			cur_started = 1'b1;
			if (cur_left != '0) cur_left--;
			if (slice_cnt != '0) slice_cnt--;
		end
		sched_clock += 1'b1;
		r.all_idle = (cur_id == '0);
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	// Send one tick request; enter and leave at a falling edge
	task automatic send_tick(input logic av, input logic [ID_W-1:0] id,
		input logic [SERV_W-1:0] serv);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		arrive_valid <= av;
		arrive_id <= id;
		arrive_service <= serv;
		do @(posedge clk); while (!in_ready);
		pending_ticks.insert(pending_ticks.size(), schedule_tick(av, id, serv));
		@(negedge clk);
	endtask

	// Send a request with random content; arrive_pct percent carry a job
	task automatic send_random(input int arrive_pct, input int serv_max);
		logic              av;
		logic [ID_W-1:0]   id;
		logic [SERV_W-1:0] serv;
		av = ($urandom_range(0, 99) < arrive_pct);
		if (av) begin
			id = ($urandom_range(0, 31) == 0) ? '0 : ID_W'($urandom_range(1, 255));
			serv = ($urandom_range(0, 39) == 0) ? '0 : SERV_W'($urandom_range(1, serv_max));
		end else begin
			id = ID_W'($urandom);
			serv = SERV_W'($urandom);
		end
		send_tick(av, id, serv);
	endtask

	// Hold off requests until every expected result has arrived, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_ticks.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write all five registers, then poke one index that decodes to nothing
	task automatic configure(input logic [QNT_W-1:0] q0, q1, q2, q3, ovh);
		logic [QNT_W-1:0] vals [5];
		vals = '{q0, q1, q2, q3, ovh};
		for (int i = 0; i <= int'(REG_SWITCH_OVH); i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= vals[i];
			if (CFG_IDX_W'(i) == REG_SWITCH_OVH) overhead_cfg = vals[i];
			else quantum_cfg[i] = vals[i];
			@(negedge clk);
		end
		cfg_index <= REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, SPARE_REGS - 1));
		cfg_wdata <= QNT_W'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random receiver stalls in bursts while idle_on is set
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		err_count++;
		// keep the log short when the block is badly off
		if (err_count <= PRINT_CAP) $display("MISMATCH result %0d: %s", result_count, msg);
	endtask

	task automatic check_field(input string name, input longint unsigned got,
		input longint unsigned want);
		if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	always @(posedge clk) begin : check_results
		tick_result_t want;
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("multilevel_feedback_queue_scheduler verification failed");
			$finish;
		end else if (arst_n && out_valid && out_ready) begin
			if (pending_ticks.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, run_id %0d", run_id));
			end else begin
				want = pending_ticks.pop_front();
				check_field("run_id", run_id, want.run_id);
				check_field("run_level", run_level, want.run_level);
				check_field("time_now", time_now, want.time_now);
				check_field("first_run", first_run, want.first_run);
				check_field("done_valid", done_valid, want.done_valid);
				check_field("done_id", done_id, want.done_id);
				check_field("done_time", done_time, want.done_time);
				check_field("all_idle", all_idle, want.all_idle);
				check_field("arrival_dropped", arrival_dropped, want.arrival_dropped);
			end
			result_count++;
		end
	end

	// ---------------------------------------------------------------- tests

	// Idle ticks, ignored arrivals, zero service, a lone job and a long job
	task automatic test_directed_cases();
		configure(QUANTUM_RESET, QUANTUM_RESET, QUANTUM_RESET, QUANTUM_RESET, '0);
		send_tick(1'b0, '0, '0);
		send_tick(1'b0, '0, '0);
		// arrival with id zero is ignored
		send_tick(1'b1, '0, '1);
		// payload without arrival_valid is ignored
		send_tick(1'b0, '1, '1);
		// zero service runs one tick
		send_tick(1'b1, ID_W'(1), '0);
		send_tick(1'b0, '0, '0);
		send_tick(1'b0, '0, '0);
		// lone job keeps getting fresh slices at its level
		send_tick(1'b1, ID_W'(2), SERV_W'(3));
		repeat (4) send_tick(1'b0, '0, '0);
		// long job at the field extremes, then short ones preempt it
		send_tick(1'b1, '1, '1);
		send_tick(1'b1, ID_W'(3), SERV_W'(2));
		send_tick(1'b1, ID_W'(4), SERV_W'(1));
		repeat (6) send_tick(1'b0, '0, '0);
		drain_results();
	endtask

	// Moderate load with doubling quanta and a small switch cost
	task automatic test_mixed_load();
		configure(8'd1, 8'd2, 8'd4, 8'd8, 8'd1);
		repeat (500) send_random(35, 24);
		drain_results();
	endtask

	// Long level-0 slice and heavy arrivals fill level 0 and drop arrivals
	task automatic test_level0_overflow();
		configure(8'd255, 8'd3, 8'd6, 8'd12, 8'd255);
		repeat (150) send_random(90, 64);
		// let every outstanding result come back before continuing
		drain_results();
		repeat (150) send_random(90, 64);
		drain_results();
	endtask

	// One-tick level-0 slice pushes jobs down until level 1 fills up
	task automatic test_demotion_backlog();
		configure(8'd1, 8'd255, 8'd0, 8'd0, 8'd0);
		repeat (300) send_random(85, 300);
		drain_results();
	endtask

	// Sparse arrivals on random settings let the queues drain
	task automatic test_light_load();
		configure(QNT_W'($urandom_range(0, 16)), QNT_W'($urandom_range(0, 16)),
			QNT_W'($urandom_range(0, 16)), QNT_W'($urandom_range(0, 16)),
			QNT_W'($urandom_range(0, 8)));
		repeat (350) send_random(10, 32);
		drain_results();
	endtask

	// Full-rate traffic on both sides with random settings
	task automatic test_back_to_back();
		configure(QNT_W'($urandom_range(1, 255)), QNT_W'($urandom_range(0, 255)),
			QNT_W'($urandom_range(0, 255)), QNT_W'($urandom_range(0, 255)),
			QNT_W'($urandom_range(0, 255)));
		idle_on = 1'b0;
		repeat (480) send_random(40, 20);
		drain_results();
	endtask

	initial begin
		reset_schedule();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_mixed_load();
		test_level0_overflow();
		test_demotion_backlog();
		test_light_load();
		test_back_to_back();
		if (err_count == 0 && pending_ticks.size() == 0) begin
			$display("multilevel_feedback_queue_scheduler verification clean");
		end else begin
			$display("multilevel_feedback_queue_scheduler verification failed");
		end
		$finish;
	end

endmodule
